// ===== hw/rtl/triangle_arrow_classifier_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef TRIANGLE_ARROW_CLASSIFIER_MACROS_SVH
`define TRIANGLE_ARROW_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define TAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("classifier check failed");
`define TAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("classifier check failed");
`else
`define TAC_ASSERT_IMP(lbl, ante, cons)
`define TAC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

	localparam int CoordBits = 12;
	localparam int InW       = 12;
	localparam int AreaW     = 24;
	localparam int TolW      = 10;
	localparam int FracBits  = 4;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 24;

	localparam int RootW     = CoordBits + FracBits + 1;
	localparam int LaneLat   = RootW + 2;
	localparam int PipeDepth = LaneLat + 2;

	localparam logic [AreaW-1:0] AreaLowRst  = AreaW'(100);
	localparam logic [AreaW-1:0] AreaHighRst = AreaW'(500);
	localparam logic [TolW-1:0]  SideTolRst  = TolW'(102);

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic [InW-1:0]       in_coord_t;
	typedef logic [RootW-1:0]     len_t;

	typedef enum logic [CfgIdxW-1:0] {
		RegAreaLow  = 2'd0,
		RegAreaHigh = 2'd1,
		RegSideTol  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic area_ok;
		logic down;
	} side_t;

	function automatic coord_t to_coord(in_coord_t v);
		logic [InW+CoordBits-1:0] w;
		w = {{CoordBits{1'b0}}, v};
		return w[CoordBits-1:0];
	endfunction

	function automatic len_t len_diff(len_t a, len_t b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

// ===== hw/rtl/tac_lane.sv =====
module tac_lane import tac_pkg::*; (
	input  logic               clk,
	input  logic [LaneLat-1:0] en,
	input  coord_t             ax,
	input  coord_t             ay,
	input  coord_t             bx,
	input  coord_t             by,
	output len_t               len
);

	localparam int SqW  = 2 * CoordBits;
	localparam int D2W  = SqW + 1;
	localparam int RadW = 2 * RootW;
	localparam int RemW = RootW + 2;
	localparam int CurW = RemW + 2;

	coord_t         dx, dy;
	logic [SqW-1:0] dx2_s1, dy2_s1;
	logic [D2W-1:0] d2_s2;
	logic [RadW-1:0] rad_s [RootW];
	logic [RemW-1:0] rem_s [RootW];
	len_t            root_s [RootW];

	assign dx = (ax > bx) ? ax - bx : bx - ax;
	assign dy = (ay > by) ? ay - by : by - ay;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx2_s1 <= SqW'(dx) * SqW'(dx);
			dy2_s1 <= SqW'(dy) * SqW'(dy);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d2_s2 <= D2W'(dx2_s1) + D2W'(dy2_s1);
		end
	end

	// one root bit per stage, radicand is d2 scaled by 2^(2*FracBits)
	for (genvar k = 0; k < RootW; k++) begin : g_root
		logic [RadW-1:0] rad_in;
		logic [RemW-1:0] rem_in;
		len_t            root_in;
		logic [CurW-1:0] cur;
		logic [CurW-1:0] trial;

		if (k == 0) begin : g_first
			assign rad_in  = RadW'({d2_s2, {(2 * FracBits){1'b0}}});
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign cur   = {rem_in, rad_in[RadW-1-2*k -: 2]};
		assign trial = CurW'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en[k+2]) begin
				rad_s[k] <= rad_in;
				if (cur >= trial) begin
					rem_s[k]  <= RemW'(cur - trial);
					root_s[k] <= {root_in[RootW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= RemW'(cur);
					root_s[k] <= {root_in[RootW-2:0], 1'b0};
				end
			end
		end
	end

	assign len = root_s[RootW-1];

endmodule

// ===== hw/rtl/tac_merge.sv =====
module tac_merge import tac_pkg::*; (
	input  logic            clk,
	input  logic [1:0]      en,
	input  len_t            len_ab,
	input  len_t            len_ac,
	input  len_t            len_bc,
	input  logic [TolW-1:0] side_tolerance,
	input  side_t           side_in,
	output logic            accepted,
	output logic            points_down
);

	localparam int LimW = TolW + RootW;

	logic [LimW-1:0] limit_s1;
	len_t            d_acbc_s1, d_acab_s1, d_bcab_s1;
	side_t           side_s1;
	logic            iso;
	logic            acc_s2, down_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			limit_s1  <= LimW'(side_tolerance) * LimW'(len_ab);
			d_acbc_s1 <= len_diff(len_ac, len_bc);
			d_acab_s1 <= len_diff(len_ac, len_ab);
			d_bcab_s1 <= len_diff(len_bc, len_ab);
			side_s1   <= side_in;
		end
	end

	// scaling the difference by 2^TolW puts both sides in Q13.14
	assign iso = ({d_acbc_s1, {TolW{1'b0}}} <= limit_s1) ||
	             ({d_acab_s1, {TolW{1'b0}}} <= limit_s1) ||
	             ({d_bcab_s1, {TolW{1'b0}}} <= limit_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			acc_s2  <= iso && side_s1.area_ok;
			down_s2 <= iso && side_s1.area_ok && side_s1.down;
		end
	end

	assign accepted    = acc_s2;
	assign points_down = down_s2;

endmodule

// ===== hw/rtl/triangle_arrow_classifier.sv =====
// channel | direction | handshake             | payload
// cfg     | in        | cfg_we                | cfg_index, cfg_data
// input   | in        | in_valid / in_ready   | first_x .. third_y
// result  | out       | out_valid / out_ready | accepted, points_down
//
// One triangle per cycle unless a full pipeline waits on out_ready; PipeDepth
// stages, made up of the three side length lanes, each a square stage, a sum
// stage and a 17-stage root pipeline, followed by two merge stages.
// Stages advance independently, so bubbles close up behind a stalled result.
// arst_n clears the stage valids and loads the register defaults.
`include "triangle_arrow_classifier_macros.svh"

module triangle_arrow_classifier import tac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_coord_t           first_x,
	input  in_coord_t           first_y,
	input  in_coord_t           second_x,
	input  in_coord_t           second_y,
	input  in_coord_t           third_x,
	input  in_coord_t           third_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic                points_down
);

	localparam int ProdW   = 2 * CoordBits + 2;
	localparam int CrossW  = ProdW + 1;
	localparam int TwiceW  = CrossW - 1;
	localparam int CmpW    = (TwiceW > AreaW + 1) ? TwiceW : AreaW + 1;

	logic [AreaW-1:0] area_low_q, area_high_q;
	logic [TolW-1:0]  side_tol_q;

	logic [PipeDepth-1:0] vld_q;
	logic [PipeDepth-1:0] rdy;

	coord_t ax, ay, bx, by, cx, cy;
	len_t   len_ab, len_ac, len_bc;

	logic signed [CoordBits:0] d_bc, d_ca, d_ab;
	logic signed [ProdW-1:0]   prod_s1 [3];
	logic                      dn_s1;
	logic signed [CrossW-1:0]  cross_sum;
	logic [TwiceW-1:0]         twice_s2;
	logic                      dn_s2;
	side_t                     side_s [2:LaneLat-1];

	coord_t           ymin, ymax;
	logic [CoordBits:0] ysum;
	logic             n_a, n_b, n_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_low_q  <= AreaLowRst;
			area_high_q <= AreaHighRst;
			side_tol_q  <= SideTolRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegAreaLow:  area_low_q  <= cfg_data[AreaW-1:0];
				RegAreaHigh: area_high_q <= cfg_data[AreaW-1:0];
				RegSideTol:  side_tol_q  <= cfg_data[TolW-1:0];
				default: ;
			endcase
		end
	end

	// a stage takes new data when it or any stage past it is empty, or the result is taken
	always_comb begin
		for (int k = 0; k < PipeDepth; k++) begin
			rdy[k] = out_ready || !(&(vld_q | ~({PipeDepth{1'b1}} << k)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < PipeDepth; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[PipeDepth-1];

	assign ax = to_coord(first_x);
	assign ay = to_coord(first_y);
	assign bx = to_coord(second_x);
	assign by = to_coord(second_y);
	assign cx = to_coord(third_x);
	assign cy = to_coord(third_y);

	tac_lane u_lane_ab (
		.clk (clk),
		.en  (rdy[LaneLat-1:0]),
		.ax  (ax),
		.ay  (ay),
		.bx  (bx),
		.by  (by),
		.len (len_ab)
	);

	tac_lane u_lane_ac (
		.clk (clk),
		.en  (rdy[LaneLat-1:0]),
		.ax  (ax),
		.ay  (ay),
		.bx  (cx),
		.by  (cy),
		.len (len_ac)
	);

	tac_lane u_lane_bc (
		.clk (clk),
		.en  (rdy[LaneLat-1:0]),
		.ax  (bx),
		.ay  (by),
		.bx  (cx),
		.by  (cy),
		.len (len_bc)
	);

	// shoelace terms
	assign d_bc = $signed({1'b0, by}) - $signed({1'b0, cy});
	assign d_ca = $signed({1'b0, cy}) - $signed({1'b0, ay});
	assign d_ab = $signed({1'b0, ay}) - $signed({1'b0, by});

	// near the minimum row: 2y <= ymin + ymax
	always_comb begin
		ymin = ay;
		ymax = ay;
		if (by < ymin) ymin = by;
		if (cy < ymin) ymin = cy;
		if (by > ymax) ymax = by;
		if (cy > ymax) ymax = cy;
	end

	assign ysum = (CoordBits + 1)'(ymin) + (CoordBits + 1)'(ymax);
	assign n_a  = {ay, 1'b0} <= ysum;
	assign n_b  = {by, 1'b0} <= ysum;
	assign n_c  = {cy, 1'b0} <= ysum;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			prod_s1[0] <= ProdW'($signed({1'b0, ax})) * ProdW'(d_bc);
			prod_s1[1] <= ProdW'($signed({1'b0, bx})) * ProdW'(d_ca);
			prod_s1[2] <= ProdW'($signed({1'b0, cx})) * ProdW'(d_ab);
			dn_s1      <= !((n_a ^ n_b ^ n_c) && !(n_a && n_b && n_c));
		end
	end

	assign cross_sum = CrossW'(prod_s1[0]) + CrossW'(prod_s1[1]) + CrossW'(prod_s1[2]);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			twice_s2 <= (cross_sum < 0) ? TwiceW'(-cross_sum) : TwiceW'(cross_sum);
			dn_s2    <= dn_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			side_s[2].area_ok <= (CmpW'(twice_s2) > CmpW'({area_low_q, 1'b0})) &&
			                     (CmpW'(twice_s2) < CmpW'({area_high_q, 1'b0}));
			side_s[2].down    <= dn_s2;
		end
		for (int k = 3; k < LaneLat; k++) begin
			if (rdy[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	tac_merge u_merge (
		.clk            (clk),
		.en             (rdy[PipeDepth-1:LaneLat]),
		.len_ab         (len_ab),
		.len_ac         (len_ac),
		.len_bc         (len_bc),
		.side_tolerance (side_tol_q),
		.side_in        (side_s[LaneLat-1]),
		.accepted       (accepted),
		.points_down    (points_down)
	);

`TAC_ASSERT_IMP(a_down_needs_accept, out_valid && points_down, accepted)
`TAC_ASSERT_IMP(a_stall_only_when_full, !in_ready, &vld_q)
`TAC_ASSERT_NXT(a_taken_lands_in_first_stage, in_valid && in_ready, vld_q[0])

endmodule

// ===== tb/triangle_arrow_classifier_test.sv =====
module triangle_arrow_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tac_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int SettleCycles  = PipeDepth + 4;
	localparam int CoordMax      = (1 << CoordBits) - 1;
	localparam logic [CfgIdxW-1:0] RegBeyond = 2'd3;

	typedef struct {
		logic is_accepted;
		logic is_down;
	} verdict_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	in_coord_t           first_x;
	in_coord_t           first_y;
	in_coord_t           second_x;
	in_coord_t           second_y;
	in_coord_t           third_x;
	in_coord_t           third_y;
	logic                out_valid;
	logic                out_ready;
	logic                accepted;
	logic                points_down;

	verdict_t expected_verdicts[$];
	int       fail_count   = 0;
	int       quiet_cycles = 0;
	bit       steady       = 1'b0;

	longint area_low_now  = longint'(AreaLowRst);
	longint area_high_now = longint'(AreaHighRst);
	longint tolerance_now = longint'(SideTolRst);

	triangle_arrow_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.third_x    (third_x),
		.third_y    (third_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.points_down(points_down)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Side lengths and the window test, computed exactly in 64 bits.
	function automatic longint root_floor(longint v);
		longint r;
		longint t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic longint side_q4(int x0, int y0, int x1, int y1);
		longint dx;
		longint dy;
		dx = longint'(x1) - longint'(x0);
		dy = longint'(y1) - longint'(y0);
		return root_floor((dx * dx + dy * dy) * 256);
	endfunction

	function automatic longint gap_between(longint a, longint b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic verdict_t predict_verdict(int ax, int ay, int bx, int by, int cx, int cy);
		longint   cross_val;
		longint   twice_area;
		longint   s_ab;
		longint   s_ac;
		longint   s_bc;
		longint   allowance;
		int       ymin;
		int       ymax;
		int       near_top;
		logic     in_window;
		logic     isosceles;
		verdict_t v;
		cross_val = longint'(ax) * (by - cy) + longint'(bx) * (cy - ay) +
			longint'(cx) * (ay - by);
		twice_area = (cross_val < 0) ? -cross_val : cross_val;
		in_window = (twice_area > 2 * area_low_now) && (twice_area < 2 * area_high_now);
		s_ab = side_q4(ax, ay, bx, by);
		s_ac = side_q4(ax, ay, cx, cy);
		s_bc = side_q4(bx, by, cx, cy);
		allowance = tolerance_now * s_ab;
		isosceles = (gap_between(s_ac, s_bc) * 1024 <= allowance) ||
			(gap_between(s_ac, s_ab) * 1024 <= allowance) ||
			(gap_between(s_bc, s_ab) * 1024 <= allowance);
		v.is_accepted = in_window && isosceles;
		v.is_down = 1'b0;
		if (v.is_accepted) begin
			ymin = ay;
			ymax = ay;
			if (by < ymin) ymin = by;
			if (cy < ymin) ymin = cy;
			if (by > ymax) ymax = by;
			if (cy > ymax) ymax = cy;
			// ties go to the minimum row
			near_top = ((ay - ymin) <= (ymax - ay)) + ((by - ymin) <= (ymax - by)) +
				((cy - ymin) <= (ymax - cy));
			v.is_down = (near_top != 1);
		end
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_triangle(input int ax, input int ay, input int bx, input int by,
			input int cx, input int cy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_x  <= in_coord_t'(ax);
		first_y  <= in_coord_t'(ay);
		second_x <= in_coord_t'(bx);
		second_y <= in_coord_t'(by);
		third_x  <= in_coord_t'(cx);
		third_y  <= in_coord_t'(cy);
		do @(posedge clk); while (!in_ready);
		expected_verdicts.push_back(predict_verdict(ax, ay, bx, by, cx, cy));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			RegAreaLow:  area_low_now  = longint'(data[AreaW-1:0]);
			RegAreaHigh: area_high_now = longint'(data[AreaW-1:0]);
			RegSideTol:  tolerance_now = longint'(data[TolW-1:0]);
			default: ;
		endcase
	endtask

	task automatic send_random_triangle(input int span);
		int mode;
		int half;
		int height;
		int ox;
		int oy;
		int jx;
		int jy;
		int rot;
		int px[3];
		int py[3];
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// near-isosceles shape with its apex in one of four directions
			half   = $urandom_range(1, span);
			height = $urandom_range(1, 2 * span);
			ox = $urandom_range(2 * span + 1, CoordMax - 2 * span - 1);
			oy = $urandom_range(2 * span + 1, CoordMax - 2 * span - 1);
			jx = int'($urandom_range(0, 2)) - 1;
			jy = int'($urandom_range(0, 2)) - 1;
			case ($urandom_range(0, 3))
				0: begin
					px = '{ox - half, ox + half, ox + jx};
					py = '{oy, oy, oy - height + jy};
				end
				1: begin
					px = '{ox - half, ox + half, ox + jx};
					py = '{oy, oy, oy + height + jy};
				end
				2: begin
					px = '{ox, ox, ox - height + jx};
					py = '{oy - half, oy + half, oy + jy};
				end
				default: begin
					px = '{ox, ox, ox + height + jx};
					py = '{oy - half, oy + half, oy + jy};
				end
			endcase
		end else if (mode < 8) begin
			for (int i = 0; i < 3; i++) begin
				px[i] = $urandom_range(0, CoordMax);
				py[i] = $urandom_range(0, CoordMax);
			end
		end else begin
			ox = $urandom_range(0, CoordMax - 2 * span);
			oy = $urandom_range(0, CoordMax - 2 * span);
			for (int i = 0; i < 3; i++) begin
				px[i] = ox + int'($urandom_range(0, 2 * span));
				py[i] = oy + int'($urandom_range(0, 2 * span));
			end
		end
		rot = $urandom_range(0, 2);
		send_triangle(px[rot], py[rot], px[(rot + 1) % 3], py[(rot + 1) % 3],
			px[(rot + 2) % 3], py[(rot + 2) % 3]);
	endtask

	task automatic set_window(input longint low, input longint high, input longint tol);
		logic [CfgDataW-1:0] tol_word;
		tol_word = CfgDataW'($urandom);
		tol_word[TolW-1:0] = tol[TolW-1:0];
		drain_results();
		write_reg(RegAreaLow, low[CfgDataW-1:0]);
		write_reg(RegAreaHigh, high[CfgDataW-1:0]);
		write_reg(RegSideTol, tol_word);
	endtask

	task automatic test_directed_shapes();
		send_triangle(0, 0, 0, 0, 0, 0);
		send_triangle(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
		send_triangle(0, 0, CoordMax, 0, 2048, CoordMax);
		send_triangle(0, 0, 20, 0, 10, 20);
		send_triangle(10, 0, 0, 20, 20, 20);
		send_triangle(100, 100, 100, 100, 130, 140);
		send_triangle(0, 0, 10, 10, 20, 20);
		send_triangle(0, 0, 20, 10, 0, 20);
		send_triangle(4075, 4000, CoordMax, 4020, 4075, 4040);
		send_triangle(0, 0, 20, 0, 12, 20);
		send_triangle(0, 0, 30, 0, 14, 15);
	endtask

	task automatic test_area_window();
		set_window(200, 500, 102);
		send_triangle(0, 0, 20, 0, 10, 20);
		set_window(199, 500, 102);
		send_triangle(0, 0, 20, 0, 10, 20);
		set_window(0, 200, 102);
		send_triangle(0, 0, 20, 0, 10, 20);
		set_window(0, 201, 102);
		send_triangle(0, 0, 20, 0, 10, 20);
		send_triangle(0, 0, 1, 0, 0, 1);
		set_window(150, 151, 1023);
		send_triangle(0, 0, 20, 0, 10, 20);
		send_triangle(0, 0, 30, 0, 15, 10);
		set_window(0, 24'hFFFFFF, 102);
		send_triangle(0, 0, CoordMax, 0, 2048, CoordMax);
		send_triangle(CoordMax, 0, 0, CoordMax, CoordMax, CoordMax);
		send_triangle(0, 0, 0, 0, 5, 9);
		set_window(24'hFFFFFF, 24'hFFFFFF, 1023);
		send_triangle(0, 0, CoordMax, 0, 2048, CoordMax);
		// a write outside the register map must leave every register alone
		set_window(100, 500, 102);
		write_reg(RegBeyond, 24'h000005);
		send_triangle(0, 0, 20, 0, 10, 20);
	endtask

	task automatic test_side_tolerance();
		drain_results();
		write_reg(RegSideTol, 24'hFFFC00);
		send_triangle(0, 0, 20, 0, 10, 20);
		send_triangle(0, 0, 20, 0, 11, 20);
		drain_results();
		write_reg(RegSideTol, 24'h0003FF);
		send_triangle(0, 0, 20, 0, 11, 20);
		send_triangle(0, 0, 30, 0, 3, 25);
	endtask

	task automatic test_random_settings();
		longint low;
		set_window(longint'(AreaLowRst), longint'(AreaHighRst), longint'(SideTolRst));
		repeat (110) send_random_triangle(30);
		set_window(100, 500, 0);
		repeat (100) send_random_triangle(30);
		set_window(100, 500, 1023);
		repeat (100) send_random_triangle(30);
		set_window(0, 24'hFFFFFF, 102);
		repeat (100) send_random_triangle(900);
		set_window(150, 151, 1023);
		repeat (60) send_random_triangle(30);
		for (int k = 0; k < 3; k++) begin
			low = longint'($urandom_range(0, 4000));
			set_window(low, low + longint'($urandom_range(0, 8000)),
				longint'($urandom_range(0, 1023)));
			repeat (100) send_random_triangle(60);
		end
		// back-to-back traffic with the result side always ready
		set_window(100, 500, 102);
		steady = 1'b1;
		repeat (110) send_random_triangle(30);
		drain_results();
		steady = 1'b0;
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= RegAreaLow;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		first_x   <= '0;
		first_y   <= '0;
		second_x  <= '0;
		second_y  <= '0;
		third_x   <= '0;
		third_y   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_shapes();
		test_area_window();
		test_side_tolerance();
		test_random_settings();
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0 && expected_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_sink
		int run;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 24);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				out_ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected transaction: accepted=%0b points_down=%0b",
					accepted, points_down);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (accepted !== want.is_accepted) begin
					$error("accepted: expected %0b, got %0b", want.is_accepted, accepted);
					fail_count++;
				end
				if (points_down !== want.is_down) begin
					$error("points_down: expected %0b, got %0b", want.is_down, points_down);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

// ===== triangle_arrow_classifier.f =====
+incdir+hw/rtl
hw/rtl/tac_pkg.sv
hw/rtl/tac_lane.sv
hw/rtl/tac_merge.sv
hw/rtl/triangle_arrow_classifier.sv
tb/triangle_arrow_classifier_test.sv
